FILE: design/hsfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_pkg: shared types, constants and functions
// CRC-8 step, fixed-point scaling constants and the divide-by-65535 helper
// used by the sensor frame check and convert block.
// ----------------------------------------------------------------------------
package hsfc_pkg;

    // crc-8, polynomial x^8+x^5+x^4+1, msb first
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // field widths
    localparam int WORD_W  = 16;
    localparam int TEMP_W  = 15;
    localparam int HUM_W   = 14;
    localparam int TPROD_W = 31;
    localparam int HPROD_W = 30;

    // scaling: temp = floor(raw*17500/65535) - 4500, rh = floor(raw*10000/65535)
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;

    // byte position within a frame
    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } frame_pos_t;

    // frame parser to result stage
    typedef struct packed {
        logic                      done;
        logic                      good;
        logic [WORD_W-1:0]         temp_word;
        logic [WORD_W-1:0]         hum_word;
        logic signed [TEMP_W-1:0]  temp_conv;
        logic [HPROD_W-1:0]        hum_prod;
    } frame_res_t;

    // one byte of crc, unrolled over eight bits
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // floor(x / 65535) for x below 2^31: x = q0*65536 + lo, so x = q0*65535 + (lo + q0)
    // and lo + q0 stays below twice the divisor, one correction step
    function automatic logic [15:0] div_65535(input logic [30:0] x);
        logic [14:0] q0;
        logic [16:0] r;
        logic [15:0] q;
        q0 = x[30:16];
        r  = {1'b0, x[15:0]} + {2'b00, q0};
        q  = {1'b0, q0} + {15'd0, (r >= 17'd65535)};
        return q;
    endfunction

endpackage

FILE: design/hsfc_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_stream_if: valid/ready channels of the frame check block
// Byte channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface hsfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface hsfc_result_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] temperature;
    logic [13:0]        humidity;
    logic [15:0]        raw_temp;
    logic [15:0]        raw_hum;
    logic               status;

    modport source (output valid, output temperature, output humidity,
                    output raw_temp, output raw_hum, output status, input ready);
    modport sink   (input valid, input temperature, input humidity,
                    input raw_temp, input raw_hum, input status, output ready);
endinterface

FILE: design/hsfc_frame_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_frame_parse: byte position tracking and crc check
// Assembles the two words, runs the crc over each, precomputes the
// temperature conversion and flags the sixth byte of a frame.
// ----------------------------------------------------------------------------
module hsfc_frame_parse
    import hsfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] rx_byte,
    input  logic       frame_start,
    output frame_res_t res
);

    frame_pos_t          pos_reg, pos_next, pos_eff;
    logic [7:0]          crc_reg, crc_next, crc_base, crc_calc;
    logic [WORD_W-1:0]   temp_word_reg, temp_word_next;
    logic [WORD_W-1:0]   hum_word_reg, hum_word_next;
    logic                temp_good_reg, temp_good_next;
    logic [TPROD_W-1:0]  temp_prod_reg, temp_prod_next;
    logic [TEMP_W-1:0]   temp_conv_reg, temp_conv_next;
    logic [WORD_W-1:0]   temp_quot;
    logic                crc_match;
    logic                frame_done, frame_good;
    logic [HPROD_W-1:0]  hum_prod;

    // a frame start mark always forces byte 0
    assign pos_eff   = frame_start ? POS_T_HI : pos_reg;
    assign crc_base  = (pos_eff == POS_T_HI || pos_eff == POS_H_HI) ? CRC_INIT : crc_reg;
    assign crc_calc  = crc8_step(crc_base, rx_byte);
    assign crc_match = (crc_reg == rx_byte);

    // temperature product, then scaled value one byte later
    assign temp_prod_next = {15'd0, temp_word_reg} * {16'd0, TEMP_SCALE};
    assign temp_quot      = div_65535(temp_prod_reg);
    assign temp_conv_next = temp_quot[TEMP_W-1:0] - TEMP_OFFSET;

    // next state per byte position
    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        hum_word_next  = hum_word_reg;
        temp_good_next = temp_good_reg;
        frame_done     = 1'b0;
        frame_good     = 1'b0;
        if (fire)
        begin
            case (pos_eff)
                POS_T_HI:
                begin
                    temp_word_next = {rx_byte, 8'h00};
                    crc_next       = crc_calc;
                    pos_next       = POS_T_LO;
                end
                POS_T_LO:
                begin
                    temp_word_next = {temp_word_reg[15:8], rx_byte};
                    crc_next       = crc_calc;
                    pos_next       = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    temp_good_next = crc_match;
                    crc_next       = CRC_INIT;
                    pos_next       = POS_H_HI;
                end
                POS_H_HI:
                begin
                    hum_word_next = {rx_byte, 8'h00};
                    crc_next      = crc_calc;
                    pos_next      = POS_H_LO;
                end
                POS_H_LO:
                begin
                    hum_word_next = {hum_word_reg[15:8], rx_byte};
                    crc_next      = crc_calc;
                    pos_next      = POS_H_CRC;
                end
                POS_H_CRC:
                begin
                    frame_done = 1'b1;
                    frame_good = temp_good_reg && crc_match;
                    crc_next   = CRC_INIT;
                    pos_next   = POS_T_HI;
                end
                default:
                begin
                    pos_next = POS_T_HI;
                    crc_next = CRC_INIT;
                end
            endcase
        end
    end

    // result fields for the sixth byte
    assign hum_prod = {14'd0, hum_word_reg} * {16'd0, HUM_SCALE};
    assign res      = {frame_done, frame_good, temp_word_reg, hum_word_reg,
                       temp_conv_reg, hum_prod};

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_T_HI;
            crc_reg       <= CRC_INIT;
            temp_word_reg <= '0;
            hum_word_reg  <= '0;
            temp_good_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_word_reg <= temp_word_next;
            hum_word_reg  <= hum_word_next;
            temp_good_reg <= temp_good_next;
        end
    end

    // temperature conversion, product on the check byte, scaled on the next byte
    always_ff @(posedge clk)
    begin
        if (fire && pos_eff == POS_T_CRC)
        begin
            temp_prod_reg <= temp_prod_next;
        end
        if (fire && pos_eff == POS_H_HI)
        begin
            temp_conv_reg <= temp_conv_next;
        end
    end

endmodule

FILE: design/humidity_sensor_frame_check_convert_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_sensor_frame_check_convert_unit: sensor frame check and convert
// Takes six frame bytes, checks both crc-8 words and reports converted
// temperature and humidity once per frame (last good readings if a crc fails).
// ----------------------------------------------------------------------------
//  channel    dir  handshake      item
//  byte_ch    in   valid/ready    rx_byte, frame_start
//  result_ch  out  valid/ready    temperature, humidity, raw_temp, raw_hum, status
//
//  one byte item is taken every cycle while byte_ch.ready is high; the result
//  of a frame passes the input register, result stage and output register
//  before it is offered on result_ch. reset clears the frame position, crc
//  and last good readings.
//  a stall on result_ch backs up through the result stage to the input
//  register; bytes keep flowing while any stage has room.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_check_convert_unit
    import hsfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    hsfc_byte_if.sink          byte_ch,
    hsfc_result_if.source      result_ch
);

    logic                     in_vld_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_start_reg;
    logic                     in_take, a_fire, b_free, b_move, out_free;
    frame_res_t               fres;

    logic                     pend_vld_reg;
    logic                     pend_good_reg;
    logic [WORD_W-1:0]        pend_temp_word_reg, pend_hum_word_reg;
    logic signed [TEMP_W-1:0] pend_temp_conv_reg;
    logic [HPROD_W-1:0]       pend_hum_prod_reg;
    logic [WORD_W-1:0]        hum_quot;
    logic [HUM_W-1:0]         hum_conv;

    logic signed [TEMP_W-1:0] last_temp_reg;
    logic [HUM_W-1:0]         last_hum_reg;

    logic                     out_vld_reg;
    logic signed [TEMP_W-1:0] out_temp_reg;
    logic [HUM_W-1:0]         out_hum_reg;
    logic [WORD_W-1:0]        out_raw_temp_reg, out_raw_hum_reg;
    logic                     out_status_reg;

    // stage flow control
    assign out_free      = !out_vld_reg || result_ch.ready;
    assign b_free        = !pend_vld_reg || out_free;
    assign b_move        = pend_vld_reg && out_free;
    assign a_fire        = in_vld_reg && b_free;
    assign byte_ch.ready = !in_vld_reg || b_free;
    assign in_take       = byte_ch.valid && byte_ch.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (a_fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg  <= byte_ch.rx_byte;
            in_start_reg <= byte_ch.frame_start;
        end
    end

    // byte parsing and crc
    hsfc_frame_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (a_fire),
        .rx_byte     (in_byte_reg),
        .frame_start (in_start_reg),
        .res         (fres)
    );

    // result stage holding the finished frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
        end
        else if (fres.done)
        begin
            pend_vld_reg <= 1'b1;
        end
        else if (b_move)
        begin
            pend_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fres.done)
        begin
            pend_good_reg      <= fres.good;
            pend_temp_word_reg <= fres.temp_word;
            pend_hum_word_reg  <= fres.hum_word;
            pend_temp_conv_reg <= fres.temp_conv;
            pend_hum_prod_reg  <= fres.hum_prod;
        end
    end

    // humidity scaling
    assign hum_quot = div_65535({1'b0, pend_hum_prod_reg});
    assign hum_conv = hum_quot[HUM_W-1:0];

    // last good readings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_temp_reg <= '0;
            last_hum_reg  <= '0;
        end
        else if (b_move && pend_good_reg)
        begin
            last_temp_reg <= pend_temp_conv_reg;
            last_hum_reg  <= hum_conv;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (b_move)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_move)
        begin
            out_temp_reg     <= pend_good_reg ? pend_temp_conv_reg : last_temp_reg;
            out_hum_reg      <= pend_good_reg ? hum_conv : last_hum_reg;
            out_raw_temp_reg <= pend_temp_word_reg;
            out_raw_hum_reg  <= pend_hum_word_reg;
            out_status_reg   <= !pend_good_reg;
        end
    end

    assign result_ch.valid       = out_vld_reg;
    assign result_ch.temperature = out_temp_reg;
    assign result_ch.humidity    = out_hum_reg;
    assign result_ch.raw_temp    = out_raw_temp_reg;
    assign result_ch.raw_hum     = out_raw_hum_reg;
    assign result_ch.status      = out_status_reg;

    // converted readings stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_temp_reg >= -15'sd4500) && (out_temp_reg <= 15'sd13000))
        else $error("temperature out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_hum_reg <= 14'd10000))
        else $error("humidity out of range");

    // a held frame result is not dropped while the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_vld_reg && !out_free) |=> pend_vld_reg)
        else $error("pending frame result lost");

    // a good frame reports exactly the last good readings
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_status_reg) |-> (out_temp_reg == last_temp_reg)
            && (out_hum_reg == last_hum_reg))
        else $error("good frame does not match stored readings");

endmodule
